FILE: rtl/awat_pkg.sv
// Package for the windowed ADC average to temperature block.
// Holds sizes, conversion constants, sequencer states and inter-module structs.
// No dependencies.
package awat_pkg;

    localparam int WINDOW_DEPTH = 10;

    localparam int SAMPLE_W = 12;
    localparam int AVG_W    = 12;
    localparam int TEMP_W   = 17;
    localparam int VALID_W  = 4;

    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int SUM_W  = SAMPLE_W + CNT_W;

    localparam int IN_TDATA_W  = ((SAMPLE_W + 7) / 8) * 8;
    localparam int OUT_FIELD_W = TEMP_W + AVG_W + VALID_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

    localparam int DVD_W  = 22;
    localparam int DVS_W  = 7;
    localparam int ITER_W = $clog2(DVD_W + 1);

    localparam int PROD_W = 2 * AVG_W;
    localparam int MV_W   = 13;
    localparam int Y_W    = DVD_W + 1;

    localparam int RECIP_W     = 23;
    localparam int RECIP_SHIFT = 29;
    localparam int QPROD_W     = DVD_W + RECIP_W;

    localparam logic [ITER_W-1:0] AVG_ITERS  = ITER_W'(AVG_W);

    localparam logic [AVG_W-1:0]        MV_FULL_SCALE = 12'd3300;
    localparam logic signed [MV_W-1:0]  MV_OFFSET     = 13'sd1430;
    localparam logic signed [11:0]      MV_GAIN       = 12'sd2000;
    localparam logic signed [Y_W-1:0]   Y_BIAS        = 23'sd217500;
    // ceil(2^29 / 87), exact for any 22-bit magnitude
    localparam logic [RECIP_W-1:0]      SLOPE_RECIP   = 23'd6170931;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RING,
        ST_AVG_START,
        ST_AVG_WAIT,
        ST_SCALE,
        ST_MV,
        ST_RECIP,
        ST_TEMP,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic commit;
    } t_ring_ctl;

    typedef struct packed {
        logic              start;
        logic [DVD_W-1:0]  dividend;
        logic [DVS_W-1:0]  divisor;
        logic [ITER_W-1:0] iters;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
    } t_div_rsp;

endpackage

FILE: rtl/awat_ring.sv
// Sample ring memory with running window sum and saturating valid count.
// Read old entry on load, write new entry and update sum on commit.
// Depends on awat_pkg.
module awat_ring (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  awat_pkg::t_ring_ctl           i_ctl,
    input  logic [awat_pkg::SAMPLE_W-1:0] i_sample,
    output logic [awat_pkg::SUM_W-1:0]    o_sum,
    output logic [awat_pkg::CNT_W-1:0]    o_count
);
    import awat_pkg::*;

    logic [SAMPLE_W-1:0] r_ring [WINDOW_DEPTH];
    logic [SAMPLE_W-1:0] r_old;
    logic [SAMPLE_W-1:0] r_sample;
    logic [SLOT_W-1:0]   r_slot;
    logic [CNT_W-1:0]    r_count;
    logic [SUM_W-1:0]    r_sum;

    logic [SLOT_W-1:0]   n_slot;
    logic [CNT_W-1:0]    n_count;
    logic [SUM_W-1:0]    n_sum;
    logic                w_full;

    assign w_full = (r_count == CNT_W'(WINDOW_DEPTH));

    always_comb begin
        n_slot  = (r_slot == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : r_slot + 1'b1;
        n_count = w_full ? r_count : r_count + 1'b1;
        if (w_full) begin
            n_sum = r_sum - SUM_W'(r_old) + SUM_W'(r_sample);
        end else begin
            n_sum = r_sum + SUM_W'(r_sample);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_old    <= r_ring[r_slot];
            r_sample <= i_sample;
        end
        if (i_ctl.commit) begin
            r_ring[r_slot] <= r_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot  <= '0;
            r_count <= '0;
            r_sum   <= '0;
        end else if (i_ctl.commit) begin
            r_slot  <= n_slot;
            r_count <= n_count;
            r_sum   <= n_sum;
        end
    end

    assign o_sum   = r_sum;
    assign o_count = r_count;

endmodule

FILE: rtl/awat_div.sv
// Restoring divider for the window mean, one quotient bit per cycle.
// The caller guarantees dividend >> iters is below the divisor.
// Depends on awat_pkg.
module awat_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  awat_pkg::t_div_req i_req,
    output awat_pkg::t_div_rsp o_rsp
);
    import awat_pkg::*;

    logic [DVS_W-1:0]  r_rem;
    logic [DVS_W-1:0]  r_divisor;
    logic [DVD_W-1:0]  r_work;
    logic [ITER_W-1:0] r_left;
    logic              r_busy;
    logic              r_done;

    logic [DVS_W:0]    w_trial;
    logic [DVS_W:0]    w_diff;
    logic              w_bit;
    logic [DVS_W-1:0]  n_rem;

    always_comb begin
        w_trial = {r_rem, r_work[DVD_W-1]};
        w_diff  = w_trial - {1'b0, r_divisor};
        w_bit   = (w_trial >= {1'b0, r_divisor});
        n_rem   = w_bit ? w_diff[DVS_W-1:0] : w_trial[DVS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem     <= DVS_W'(i_req.dividend >> i_req.iters);
            r_work    <= i_req.dividend << (ITER_W'(DVD_W) - i_req.iters);
            r_divisor <= i_req.divisor;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_work <= {r_work[DVD_W-2:0], w_bit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_left <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_left <= i_req.iters;
        end else if (r_busy) begin
            r_left <= r_left - 1'b1;
            if (r_left == ITER_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_work;

endmodule

FILE: rtl/adc_window_average_to_temperature.sv
// Channel   Dir  tdata bits (low to high)
// s_*       in   [11:0] adc_sample, [15:12] zero
// m_*       out  [16:0] temperature_centi, [28:17] average_code, [32:29] valid_count
//
// With a free output a transaction runs: accept, ring update, divider start, the
// 12-iteration window mean, then scale, millivolts, reciprocal multiply for the
// division by 4.35, sign and output load. Reset clears ring pointer, count, sum and
// sequencer; ring contents are not cleared. One sample is in flight at a time; a
// finished result waits in the output register, and the next sample is taken while
// it waits.
// Depends on awat_pkg, awat_ring, awat_div.
module adc_window_average_to_temperature (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [awat_pkg::IN_TDATA_W-1:0]  i_s_tdata,   // adc_sample
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [awat_pkg::OUT_TDATA_W-1:0] o_m_tdata    // temperature_centi, average_code, valid_count
);
    import awat_pkg::*;

    t_state                   r_state;
    t_state                   n_state;
    t_ring_ctl                w_ring_ctl;
    t_div_req                 w_div_req;
    t_div_rsp                 w_div_rsp;

    logic [SUM_W-1:0]         w_sum;
    logic [CNT_W-1:0]         w_count;

    logic [AVG_W-1:0]         r_avg;
    logic [PROD_W-1:0]        r_prod;
    logic signed [Y_W-1:0]    r_y;
    logic [QPROD_W-1:0]       r_qprod;
    logic signed [TEMP_W-1:0] r_temp;
    logic                     r_m_tvalid;
    logic [OUT_TDATA_W-1:0]   r_m_tdata;

    logic signed [MV_W-1:0]   w_mv;
    logic signed [Y_W-1:0]    w_y;
    logic [DVD_W-1:0]         w_mag;
    logic [TEMP_W-1:0]        w_quo_t;
    logic                     w_s_accept;
    logic                     w_out_free;

    awat_ring u_ring (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ring_ctl),
        .i_sample (i_s_tdata[SAMPLE_W-1:0]),
        .o_sum    (w_sum),
        .o_count  (w_count)
    );

    awat_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign w_s_accept = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_m_tvalid || i_m_tready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:       if (i_s_tvalid) n_state = ST_RING;
            ST_RING:       n_state = ST_AVG_START;
            ST_AVG_START:  n_state = ST_AVG_WAIT;
            ST_AVG_WAIT:   if (w_div_rsp.done) n_state = ST_SCALE;
            ST_SCALE:      n_state = ST_MV;
            ST_MV:         n_state = ST_RECIP;
            ST_RECIP:      n_state = ST_TEMP;
            ST_TEMP:       n_state = ST_DONE;
            ST_DONE:       if (w_out_free) n_state = ST_IDLE;
            default:       n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready         = (r_state == ST_IDLE);
        w_ring_ctl.load    = (r_state == ST_IDLE) && i_s_tvalid;
        w_ring_ctl.commit  = (r_state == ST_RING);
        w_div_req.start    = 1'b0;
        w_div_req.dividend = DVD_W'(w_sum);
        w_div_req.divisor  = DVS_W'(w_count);
        w_div_req.iters    = AVG_ITERS;
        case (r_state)
            ST_AVG_START: begin
                w_div_req.start = 1'b1;
            end
            default: begin
                w_div_req.start = 1'b0;
            end
        endcase
    end

    always_comb begin
        w_mv    = MV_OFFSET - $signed({1'b0, r_prod[PROD_W-1:AVG_W]});
        w_y     = Y_W'(w_mv) * Y_W'(MV_GAIN) + Y_BIAS;
        w_mag   = DVD_W'(r_y[Y_W-1] ? -r_y : r_y);
        w_quo_t = {1'b0, r_qprod[RECIP_SHIFT +: TEMP_W-1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_AVG_WAIT) && w_div_rsp.done) begin
            r_avg <= w_div_rsp.quotient[AVG_W-1:0];
        end
        if (r_state == ST_SCALE) begin
            r_prod <= PROD_W'(r_avg) * PROD_W'(MV_FULL_SCALE);
        end
        if (r_state == ST_MV) begin
            r_y <= w_y;
        end
        if (r_state == ST_RECIP) begin
            r_qprod <= QPROD_W'(w_mag) * QPROD_W'(SLOPE_RECIP);
        end
        if (r_state == ST_TEMP) begin
            r_temp <= r_y[Y_W-1] ? -$signed(w_quo_t) : $signed(w_quo_t);
        end
        if ((r_state == ST_DONE) && w_out_free) begin
            r_m_tdata <= {{OUT_PAD_W{1'b0}}, VALID_W'(w_count), r_avg, r_temp};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if ((r_state == ST_DONE) && w_out_free) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;

    a_accept_to_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_accept |=> (r_state == ST_RING))
        else $error("accepted sample did not enter ring update");

    a_div_done_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == ST_AVG_WAIT))
        else $error("divider finished outside a wait state");

    a_mean_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCALE) |->
            (((SUM_W + 1)'(r_avg) * (SUM_W + 1)'(w_count)) <= (SUM_W + 1)'(w_sum)) &&
            (((SUM_W + 1)'(r_avg) + 1'b1) * (SUM_W + 1)'(w_count) > (SUM_W + 1)'(w_sum)))
        else $error("window mean inconsistent with sum and count");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |-> (w_count != '0))
        else $error("result formed with empty window");

endmodule
